// ----- hw/rtl/dsd_pkg.sv -----
// ----------------------------------------------------------------------------
// DSD stream file deblocker package
// Item types, result kinds, error codes and header constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_AUDIO  = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Header error codes
  localparam logic [3:0] ERR_DSD_ID     = 4'd0;
  localparam logic [3:0] ERR_DSD_SIZE   = 4'd1;
  localparam logic [3:0] ERR_FMT_ID     = 4'd2;
  localparam logic [3:0] ERR_VERSION    = 4'd3;
  localparam logic [3:0] ERR_FORMAT     = 4'd4;
  localparam logic [3:0] ERR_LAYOUT     = 4'd5;
  localparam logic [3:0] ERR_CHANNELS   = 4'd6;
  localparam logic [3:0] ERR_RATE       = 4'd7;
  localparam logic [3:0] ERR_BITS       = 4'd8;
  localparam logic [3:0] ERR_BLOCK_SIZE = 4'd9;
  localparam logic [3:0] ERR_RESERVED   = 4'd10;
  localparam logic [3:0] ERR_DATA_ID    = 4'd11;

  // Header constants
  localparam logic [6:0]  HEADER_BYTES = 7'd92;
  localparam logic [63:0] ID_DSD       = 64'h0000_0000_4453_4420;
  localparam logic [63:0] ID_FMT       = 64'h0000_0000_666D_7420;
  localparam logic [63:0] ID_DATA      = 64'h0000_0000_6461_7461;
  localparam logic [63:0] DSD_SIZE     = 64'd28;
  localparam logic [63:0] FMT_VERSION  = 64'd1;
  localparam logic [63:0] RATE_SINGLE  = 64'd2822400;
  localparam logic [63:0] RATE_DOUBLE  = 64'd5644800;
  localparam logic [63:0] BLOCK_BYTES  = 64'd4096;
  localparam logic [63:0] MAX_CHANNELS = 64'd6;
  localparam int          OFFSET_BITS  = 12;
  localparam int          BLOCKNUM_BITS = 49;

  typedef struct packed {
    logic       start_of_file;
    logic [7:0] file_byte;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  audio_byte;
    logic [2:0]  channel;
    logic [60:0] byte_index;
    logic [2:0]  channel_count;
    logic [2:0]  channel_layout;
    logic        double_rate;
    logic        msb_first;
    logic [3:0]  error_code;
    logic [63:0] sample_count;
  } result_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dsd_byte_if.sv -----
// ----------------------------------------------------------------------------
// DSD file byte channel
// Valid/ready channel carrying one file byte and its restart flag per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dsd_byte_if import dsd_pkg::*; ();
  logic       valid;
  logic       ready;
  byte_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dsd_result_if.sv -----
// ----------------------------------------------------------------------------
// DSD result channel
// Valid/ready channel carrying one audio, format or error result per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dsd_result_if import dsd_pkg::*; ();
  logic         valid;
  logic         ready;
  result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dsd_stream_file_deblocker.sv -----
// ----------------------------------------------------------------------------
// DSD stream file deblocker
//
//   channel      role    carries
//   file_stream  sink    start_of_file, file_byte
//   result       source  kind, audio_byte, channel, byte_index, format, error
//
// One byte is taken per cycle while the skid stage is empty; its result, if
// any, is registered. All parsing and block counting is a single combinational
// pass from the state registers into a result register backed by a one-item
// skid stage. file_stream.ready depends only on the skid register, so input
// keeps flowing while a result is stalled until a second result waits. rst
// is synchronous, active high, and clears the parser to the start of a header.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsd_stream_file_deblocker import dsd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  dsd_byte_if.sink      file_stream,
  dsd_result_if.source  result
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_AUDIO  = 2'd1;
  localparam logic [1:0] PH_STOP   = 2'd2;

  localparam logic [4:0] F_DSD_ID     = 5'd0;
  localparam logic [4:0] F_DSD_SIZE   = 5'd1;
  localparam logic [4:0] F_FILE_SIZE  = 5'd2;
  localparam logic [4:0] F_META_OFS   = 5'd3;
  localparam logic [4:0] F_FMT_ID     = 5'd4;
  localparam logic [4:0] F_FMT_SIZE   = 5'd5;
  localparam logic [4:0] F_VERSION    = 5'd6;
  localparam logic [4:0] F_FORMAT     = 5'd7;
  localparam logic [4:0] F_LAYOUT     = 5'd8;
  localparam logic [4:0] F_CHANNELS   = 5'd9;
  localparam logic [4:0] F_RATE       = 5'd10;
  localparam logic [4:0] F_BITS       = 5'd11;
  localparam logic [4:0] F_SAMPLES    = 5'd12;
  localparam logic [4:0] F_BLOCK_SIZE = 5'd13;
  localparam logic [4:0] F_RESERVED   = 5'd14;
  localparam logic [4:0] F_DATA_ID    = 5'd15;
  localparam logic [4:0] F_DATA_SIZE  = 5'd16;

  localparam logic [OFFSET_BITS-1:0] OFFSET_LAST = OFFSET_BITS'(BLOCK_BYTES - 64'd1);

  // Parser state
  logic [6:0]               header_position, header_position_next;
  logic [1:0]               phase, phase_next;
  logic [63:0]              field_shift, field_shift_next;
  logic [2:0]               channels_reg, channels_reg_next;
  logic [2:0]               layout_reg, layout_reg_next;
  logic                     rate_reg, rate_reg_next;
  logic                     bit_order_reg, bit_order_reg_next;
  logic [63:0]              total_samples, total_samples_next;
  logic [OFFSET_BITS-1:0]   block_offset, block_offset_next;
  logic [2:0]               channel_index, channel_index_next;
  logic [BLOCKNUM_BITS-1:0] block_number, block_number_next;

  // State as seen by this byte: a restart acts as a reset first
  logic                     sof;
  logic [7:0]               b;
  logic [6:0]               cur_hpos;
  logic [1:0]               cur_phase;
  logic [63:0]              cur_shift;
  logic [2:0]               cur_channels;
  logic [2:0]               cur_layout;
  logic                     cur_rate;
  logic                     cur_bit_order;
  logic [63:0]              cur_total;
  logic [OFFSET_BITS-1:0]   cur_offset;
  logic [2:0]               cur_chan;
  logic [BLOCKNUM_BITS-1:0] cur_block;

  logic [4:0]   fld;
  logic [6:0]   fstart;
  logic [2:0]   k;
  logic         long_field;
  logic         is_id;
  logic         field_done;
  logic [63:0]  base;
  logic [63:0]  v;
  logic [60:0]  idx;

  logic         accept;
  logic         res_valid;
  result_item_t res;

  // Output register and skid stage
  logic         out_valid;
  result_item_t out_item;
  logic         skid_valid;
  result_item_t skid_item;

  assign accept            = file_stream.valid && file_stream.ready;
  assign file_stream.ready = !skid_valid;
  assign result.valid      = out_valid;
  assign result.data       = out_item;

  assign sof           = file_stream.data.start_of_file;
  assign b             = file_stream.data.file_byte;
  assign cur_hpos      = sof ? '0 : header_position;
  assign cur_phase     = sof ? PH_HEADER : phase;
  assign cur_shift     = sof ? '0 : field_shift;
  assign cur_channels  = sof ? '0 : channels_reg;
  assign cur_layout    = sof ? '0 : layout_reg;
  assign cur_rate      = sof ? 1'b0 : rate_reg;
  assign cur_bit_order = sof ? 1'b0 : bit_order_reg;
  assign cur_total     = sof ? '0 : total_samples;
  assign cur_offset    = sof ? '0 : block_offset;
  assign cur_chan      = sof ? '0 : channel_index;
  assign cur_block     = sof ? '0 : block_number;

  // Map the header position onto its field
  always_comb begin
    case (cur_hpos) inside
      [7'd0:7'd3]:   begin fld = F_DSD_ID;     fstart = 7'd0;  end
      [7'd4:7'd11]:  begin fld = F_DSD_SIZE;   fstart = 7'd4;  end
      [7'd12:7'd19]: begin fld = F_FILE_SIZE;  fstart = 7'd12; end
      [7'd20:7'd27]: begin fld = F_META_OFS;   fstart = 7'd20; end
      [7'd28:7'd31]: begin fld = F_FMT_ID;     fstart = 7'd28; end
      [7'd32:7'd39]: begin fld = F_FMT_SIZE;   fstart = 7'd32; end
      [7'd40:7'd43]: begin fld = F_VERSION;    fstart = 7'd40; end
      [7'd44:7'd47]: begin fld = F_FORMAT;     fstart = 7'd44; end
      [7'd48:7'd51]: begin fld = F_LAYOUT;     fstart = 7'd48; end
      [7'd52:7'd55]: begin fld = F_CHANNELS;   fstart = 7'd52; end
      [7'd56:7'd59]: begin fld = F_RATE;       fstart = 7'd56; end
      [7'd60:7'd63]: begin fld = F_BITS;       fstart = 7'd60; end
      [7'd64:7'd71]: begin fld = F_SAMPLES;    fstart = 7'd64; end
      [7'd72:7'd75]: begin fld = F_BLOCK_SIZE; fstart = 7'd72; end
      [7'd76:7'd79]: begin fld = F_RESERVED;   fstart = 7'd76; end
      [7'd80:7'd83]: begin fld = F_DATA_ID;    fstart = 7'd80; end
      default:       begin fld = F_DATA_SIZE;  fstart = 7'd84; end
    endcase
  end

  always_comb begin
    case (fld)
      F_DSD_SIZE, F_FILE_SIZE, F_META_OFS, F_FMT_SIZE, F_SAMPLES, F_DATA_SIZE:
        long_field = 1'b1;
      default:
        long_field = 1'b0;
    endcase
  end

  assign k          = 3'(cur_hpos - fstart);
  assign is_id      = (fld == F_DSD_ID) || (fld == F_FMT_ID) || (fld == F_DATA_ID);
  assign field_done = long_field ? (k == 3'd7) : (k == 3'd3);
  assign base       = (k == 3'd0) ? 64'd0 : cur_shift;
  // Ids assemble as text, numbers little-endian
  assign v          = is_id ? {base[55:0], b} : (base | (64'(b) << {k, 3'b000}));
  assign idx        = {cur_block, cur_offset};

  always_comb begin
    header_position_next = cur_hpos;
    phase_next           = cur_phase;
    field_shift_next     = cur_shift;
    channels_reg_next    = cur_channels;
    layout_reg_next      = cur_layout;
    rate_reg_next        = cur_rate;
    bit_order_reg_next   = cur_bit_order;
    total_samples_next   = cur_total;
    block_offset_next    = cur_offset;
    channel_index_next   = cur_chan;
    block_number_next    = cur_block;
    res_valid            = 1'b0;
    res                  = '0;

    case (cur_phase)
      PH_HEADER: begin
        if (cur_hpos < HEADER_BYTES) begin
          field_shift_next     = v;
          header_position_next = cur_hpos + 7'd1;
          if (field_done) begin
            res.kind = KIND_ERROR;
            case (fld)
              F_DSD_ID: begin
                if (v != ID_DSD) begin res_valid = 1'b1; res.error_code = ERR_DSD_ID; end
              end
              F_DSD_SIZE: begin
                if (v != DSD_SIZE) begin res_valid = 1'b1; res.error_code = ERR_DSD_SIZE; end
              end
              F_FMT_ID: begin
                if (v != ID_FMT) begin res_valid = 1'b1; res.error_code = ERR_FMT_ID; end
              end
              F_VERSION: begin
                if (v != FMT_VERSION) begin
                  res_valid = 1'b1; res.error_code = ERR_VERSION;
                end
              end
              F_FORMAT: begin
                if (v != 64'd0) begin res_valid = 1'b1; res.error_code = ERR_FORMAT; end
              end
              F_LAYOUT: begin
                if (v < 64'd1 || v > 64'd7) begin
                  res_valid = 1'b1; res.error_code = ERR_LAYOUT;
                end
                layout_reg_next = v[2:0];
              end
              F_CHANNELS: begin
                if (v < 64'd1 || v > MAX_CHANNELS) begin
                  res_valid = 1'b1; res.error_code = ERR_CHANNELS;
                end
                channels_reg_next = v[2:0];
              end
              F_RATE: begin
                if (v != RATE_SINGLE && v != RATE_DOUBLE) begin
                  res_valid = 1'b1; res.error_code = ERR_RATE;
                end
                rate_reg_next = (v == RATE_DOUBLE);
              end
              F_BITS: begin
                if (v != 64'd1 && v != 64'd8) begin
                  res_valid = 1'b1; res.error_code = ERR_BITS;
                end
                bit_order_reg_next = (v == 64'd8);
              end
              F_SAMPLES: begin
                total_samples_next = v;
              end
              F_BLOCK_SIZE: begin
                if (v != BLOCK_BYTES) begin
                  res_valid = 1'b1; res.error_code = ERR_BLOCK_SIZE;
                end
              end
              F_RESERVED: begin
                if (v != 64'd0) begin res_valid = 1'b1; res.error_code = ERR_RESERVED; end
              end
              F_DATA_ID: begin
                if (v != ID_DATA) begin res_valid = 1'b1; res.error_code = ERR_DATA_ID; end
              end
              F_DATA_SIZE: begin
                res_valid          = 1'b1;
                res.kind           = KIND_FORMAT;
                res.channel_count  = cur_channels;
                res.channel_layout = cur_layout;
                res.double_rate    = cur_rate;
                res.msb_first      = cur_bit_order;
                res.sample_count   = cur_total;
                phase_next         = PH_AUDIO;
                block_offset_next  = '0;
                channel_index_next = '0;
                block_number_next  = '0;
              end
              default: ;
            endcase
            // Stop on the first failed check
            if (res_valid && res.kind == KIND_ERROR) begin
              phase_next = PH_STOP;
            end
          end
        end
      end

      PH_AUDIO: begin
        // Drop bytes past the last sample
        if ({idx, 3'b000} < cur_total) begin
          res_valid      = 1'b1;
          res.kind       = KIND_AUDIO;
          res.audio_byte = b;
          res.channel    = cur_chan;
          res.byte_index = idx;
        end
        if (cur_offset == OFFSET_LAST) begin
          block_offset_next = '0;
          if ({1'b0, cur_chan} + 4'd1 >= {1'b0, cur_channels}) begin
            channel_index_next = '0;
            block_number_next  = cur_block + BLOCKNUM_BITS'(1);
          end else begin
            channel_index_next = cur_chan + 3'd1;
          end
        end else begin
          block_offset_next = cur_offset + OFFSET_BITS'(1);
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= '0;
      phase           <= PH_HEADER;
      field_shift     <= '0;
      channels_reg    <= '0;
      layout_reg      <= '0;
      rate_reg        <= 1'b0;
      bit_order_reg   <= 1'b0;
      total_samples   <= '0;
      block_offset    <= '0;
      channel_index   <= '0;
      block_number    <= '0;
    end else if (accept) begin
      header_position <= header_position_next;
      phase           <= phase_next;
      field_shift     <= field_shift_next;
      channels_reg    <= channels_reg_next;
      layout_reg      <= layout_reg_next;
      rate_reg        <= rate_reg_next;
      bit_order_reg   <= bit_order_reg_next;
      total_samples   <= total_samples_next;
      block_offset    <= block_offset_next;
      channel_index   <= channel_index_next;
      block_number    <= block_number_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      // Output slot frees: refill from skid first, then from this item
      if (skid_valid) begin
        out_item   <= skid_item;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept && res_valid) begin
        out_item  <= res;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept && res_valid) begin
      // Output stalled: park this item
      skid_item  <= res;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire
